### rtl/core/pt4_pkg.sv
// Package for the 4x4 point transform: word and command types, field widths
// and the function codes of an input beat. No dependencies.

package pt4_pkg;

  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned DIM         = 4;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned RC_W        = 2;
  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned IN_BITS     = 2 * RC_W + 5 * WORD_BITS;
  localparam int unsigned IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS    = DIM * WORD_BITS;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_POINT = 1'b1
  } func_e;

  // data[0] carries the coefficient on a load, x..w on a point
  typedef struct packed {
    logic                  is_point;
    logic [IDX_W-1:0]      idx;
    logic                  last;
    word_t [DIM-1:0]       data;
  } cmd_t;

endpackage

### rtl/core/pt4_front.sv
// Front end of the point transform: registers the input beat and classifies
// it into a load or point command. Depends on pt4_pkg.

module pt4_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [pt4_pkg::IN_TDATA_W-1:0] s_axis_tdata_i,
  input  logic                          s_axis_tuser_i,
  input  logic                          s_axis_tlast_i,
  output logic                          push_valid_o,
  output pt4_pkg::cmd_t                 push_cmd_o,
  input  logic                          push_ready_i
);
  import pt4_pkg::*;

  logic  fr_valid_q, fr_valid_d;
  cmd_t  fr_cmd_q, fr_cmd_d;
  logic  accept;
  func_e func;
  logic [RC_W-1:0] row, col;
  word_t value;
  word_t [DIM-1:0] pt;

  assign s_axis_tready_o = !fr_valid_q || push_ready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign func            = func_e'(s_axis_tuser_i);
  assign row             = s_axis_tdata_i[RC_W-1:0];
  assign col             = s_axis_tdata_i[2*RC_W-1:RC_W];
  assign value           = s_axis_tdata_i[2*RC_W+WORD_BITS-1:2*RC_W];

  always_comb begin
    for (int c = 0; c < DIM; c++) begin
      pt[c] = s_axis_tdata_i[2*RC_W+(c+2)*WORD_BITS-1 -: WORD_BITS];
    end
    fr_cmd_d          = fr_cmd_q;
    fr_valid_d        = fr_valid_q;
    if (push_ready_i) fr_valid_d = 1'b0;
    if (accept) begin
      fr_valid_d        = 1'b1;
      fr_cmd_d.is_point = (func == FUNC_POINT);
      fr_cmd_d.idx      = {row, col};
      fr_cmd_d.last     = s_axis_tlast_i;
      fr_cmd_d.data     = pt;
      if (func == FUNC_LOAD) fr_cmd_d.data[0] = value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_valid_q <= 1'b0;
    end else begin
      fr_valid_q <= fr_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fr_cmd_q <= fr_cmd_d;
  end

  assign push_valid_o = fr_valid_q;
  assign push_cmd_o   = fr_cmd_q;

endmodule

### rtl/core/pt4_fifo.sv
// Command queue between front and back of the point transform.
// Register array with read and write pointers. Depends on pt4_pkg.

module pt4_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  input  pt4_pkg::cmd_t push_cmd_i,
  output logic          push_ready_o,
  output logic          pop_valid_o,
  output pt4_pkg::cmd_t pop_cmd_o,
  input  logic          pop_ready_i
);
  import pt4_pkg::*;

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  cmd_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(FIFO_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_cmd_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) cnt_d = cnt_q + CNT_W'(1);
    if (pop && !push) cnt_d = cnt_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_cmd_i;
  end

endmodule

### rtl/core/pt4_back.sv
// Back end of the point transform: coefficient store, product, pair-sum and
// row-sum stages, shift and saturation into the output register.
// Depends on pt4_pkg.

module pt4_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            pop_valid_i,
  input  pt4_pkg::cmd_t                   pop_cmd_i,
  output logic                            pop_ready_o,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [pt4_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                            m_axis_tuser_o,
  output logic                            m_axis_tlast_o
);
  import pt4_pkg::*;

  localparam int unsigned PROD_W = 2 * WORD_BITS;
  localparam int unsigned PAIR_W = PROD_W + 1;
  localparam int unsigned SUM_W  = PROD_W + 2;
  localparam word_t       ONE    = word_t'(1) << FRAC_BITS;
  localparam word_t       W_MAX  = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t       W_MIN  = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [PAIR_W-1:0] pair_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  word_t coef_q [DIM*DIM];
  prod_t p1_q [DIM][DIM];
  pair_t s2_q [DIM][2];
  sum_t  s3_q [DIM];
  word_t [DIM-1:0] out_q, out_d;
  logic  v1_q, v2_q, v3_q, v4_q;
  logic  l1_q, l2_q, l3_q, l4_q;
  logic  ovf_q, ovf_d;
  logic  en, take, load;
  sum_t  sh;
  logic [SUM_W-WORD_BITS:0] hi;

  assign en          = !v4_q || m_axis_tready_i;
  assign pop_ready_o = en;
  assign take        = en && pop_valid_i && pop_cmd_i.is_point;
  assign load        = en && pop_valid_i && !pop_cmd_i.is_point;

  always_comb begin
    ovf_d = 1'b0;
    sh    = '0;
    hi    = '0;
    for (int r = 0; r < DIM; r++) begin
      sh = s3_q[r] >>> FRAC_BITS;
      hi = sh[SUM_W-1:WORD_BITS-1];
      if ((&hi) || !(|hi)) begin
        out_d[r] = sh[WORD_BITS-1:0];
      end else begin
        out_d[r] = sh[SUM_W-1] ? W_MIN : W_MAX;
        ovf_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          coef_q[r*DIM+c] <= (r == c) ? ONE : '0;
        end
      end
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (load) coef_q[pop_cmd_i.idx] <= pop_cmd_i.data[0];
      if (en) begin
        v1_q <= take;
        v2_q <= v1_q;
        v3_q <= v2_q;
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          p1_q[r][c] <= coef_q[r*DIM+c] * pop_cmd_i.data[c];
        end
        s2_q[r][0] <= pair_t'(p1_q[r][0]) + pair_t'(p1_q[r][1]);
        s2_q[r][1] <= pair_t'(p1_q[r][2]) + pair_t'(p1_q[r][3]);
        s3_q[r]    <= sum_t'(s2_q[r][0]) + sum_t'(s2_q[r][1]);
      end
      l1_q  <= pop_cmd_i.last;
      l2_q  <= l1_q;
      l3_q  <= l2_q;
      l4_q  <= l3_q;
      out_q <= out_d;
      ovf_q <= ovf_d;
    end
  end

  assign m_axis_tvalid_o = v4_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(out_q);
  assign m_axis_tuser_o  = ovf_q;
  assign m_axis_tlast_o  = l4_q;

endmodule

### rtl/core/point_transform_4x4.sv
// 4x4 homogeneous point transform, signed fixed point, saturated results.
// A beat passes the front register, command queue, product, pair-sum and
// row-sum stages and output register. Throughput: one beat per cycle, loads
// and points alike, when the output is not stalled; 16 product multipliers.
// Reset: asynchronous, active low; queue and pipeline empty, matrix identity.
// Depends on pt4_pkg, pt4_front, pt4_fifo, pt4_back.

module point_transform_4x4 #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // coef_row, coef_col, coef_value, point_x, point_y, point_z, point_w, pad
  input  logic [pt4_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // func
  input  logic                            s_axis_tuser_i,
  input  logic                            s_axis_tlast_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // out_x, out_y, out_z, out_w
  output logic [pt4_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // overflow
  output logic                            m_axis_tuser_o,
  output logic                            m_axis_tlast_o
);
  import pt4_pkg::*;

  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_cmd, pop_cmd;

  pt4_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .push_valid_o    (push_valid),
    .push_cmd_o      (push_cmd),
    .push_ready_i    (push_ready)
  );

  pt4_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_cmd_o    (pop_cmd),
    .pop_ready_i  (pop_ready)
  );

  pt4_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pop_valid_i     (pop_valid),
    .pop_cmd_i       (pop_cmd),
    .pop_ready_o     (pop_ready),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

### rtl/core/pt4_checker.sv
// Port-level checks for point_transform_4x4, bound to the top level.
// Depends on pt4_pkg.

module pt4_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic [pt4_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input logic                            s_axis_tuser_i,
  input logic                            s_axis_tlast_i,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [pt4_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic                            m_axis_tuser_o,
  input logic                            m_axis_tlast_o
);
  import pt4_pkg::*;

  localparam word_t W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t W_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  word_t ox, oy, oz, ow;
  assign ox = m_axis_tdata_o[WORD_BITS-1:0];
  assign oy = m_axis_tdata_o[2*WORD_BITS-1:WORD_BITS];
  assign oz = m_axis_tdata_o[3*WORD_BITS-1:2*WORD_BITS];
  assign ow = m_axis_tdata_o[4*WORD_BITS-1:3*WORD_BITS];

  // stalled input beat holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && !s_axis_tready_o |=>
      s_axis_tvalid_i && $stable(s_axis_tdata_i) && $stable(s_axis_tuser_i)
      && $stable(s_axis_tlast_i))
    else $error("input beat changed while stalled");

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("output beat changed while stalled");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk_i)
    !rst_ni ##1 !rst_ni |-> !m_axis_tvalid_o)
    else $error("output valid during reset");

  // overflow flag implies a saturated lane
  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |->
      (ox == W_MAX || ox == W_MIN || oy == W_MAX || oy == W_MIN ||
       oz == W_MAX || oz == W_MIN || ow == W_MAX || ow == W_MIN))
    else $error("overflow set without a saturated lane");

  // no output beat in the first cycle out of reset
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("output beat without a preceding input beat");

endmodule

bind point_transform_4x4 pt4_checker u_pt4_checker (.*);

### tb/tb.sv
// Self-checking bench for point_transform_4x4: streams load and point beats
// with random gaps and backpressure, and checks each output beat against a
// bit-exact model of the matrix product. Depends on pt4_pkg and the RTL.

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pt4_pkg::*;

  localparam int unsigned FRAC       = 16;
  localparam int unsigned N_RANDOM   = 1550;
  localparam int unsigned MAX_CYCLES = 200000;
  localparam logic signed [67:0] SAT_MAX = 68'sh7fffffff;
  localparam logic signed [67:0] SAT_MIN = -68'sh80000000;

  typedef struct packed {
    func_e           func;
    logic [1:0]      row;
    logic [1:0]      col;
    word_t           coef;
    word_t [DIM-1:0] pt;
    logic            last;
    logic            hold;  // wait for all results before offering this beat
  } beat_t;

  typedef struct packed {
    word_t [DIM-1:0] v;
    logic            ovf;
    logic            last;
  } xform_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i  = '0;
  logic                   s_axis_tuser_i  = 1'b0;
  logic                   s_axis_tlast_i  = 1'b0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   m_axis_tuser_o;
  logic                   m_axis_tlast_o;

  beat_t  beat_q[$];
  xform_t xform_q[$];
  word_t  coef_mat[DIM*DIM];
  beat_t  cur_beat;
  int     n_sent     = 0;
  int     n_rcvd     = 0;
  int     n_err      = 0;
  int     stall_left = 0;
  bit     stalled    = 1'b0;
  int     cycles     = 0;

  point_transform_4x4 #(.FRAC_BITS(FRAC)) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic xform_t transform_point(beat_t b);
    xform_t             r;
    logic signed [67:0] acc;
    logic signed [67:0] sh;
    longint             prod;
    r.ovf  = 1'b0;
    r.last = b.last;
    for (int i = 0; i < DIM; i++) begin
      acc = '0;
      for (int j = 0; j < DIM; j++) begin
        prod = longint'($signed(coef_mat[i*DIM+j])) * longint'($signed(b.pt[j]));
        acc  = acc + prod;
      end
      sh = acc >>> FRAC;
      if (sh > SAT_MAX) begin
        r.v[i] = 32'h7fffffff;
        r.ovf  = 1'b1;
      end else if (sh < SAT_MIN) begin
        r.v[i] = 32'h80000000;
        r.ovf  = 1'b1;
      end else begin
        r.v[i] = sh[31:0];
      end
    end
    return r;
  endfunction

  function automatic word_t rand_word(bit narrow, int unsigned span_log2);
    if (narrow) return word_t'($urandom_range(0, 2**span_log2) - 2**(span_log2 - 1));
    return word_t'($urandom);
  endfunction

  function automatic beat_t mk_load(logic [1:0] row, logic [1:0] col, word_t val);
    beat_t b;
    b.func = FUNC_LOAD;
    b.row  = row;
    b.col  = col;
    b.coef = val;
    for (int i = 0; i < DIM; i++) b.pt[i] = word_t'($urandom);
    b.last = 1'($urandom);
    b.hold = 1'b0;
    return b;
  endfunction

  function automatic beat_t mk_point(word_t x, word_t y, word_t z, word_t w, logic last);
    beat_t b;
    b.func  = FUNC_POINT;
    b.row   = 2'($urandom);
    b.col   = 2'($urandom);
    b.coef  = word_t'($urandom);
    b.pt[0] = x;
    b.pt[1] = y;
    b.pt[2] = z;
    b.pt[3] = w;
    b.last  = last;
    b.hold  = 1'b0;
    return b;
  endfunction

  function automatic beat_t rand_beat();
    beat_t b;
    bit    narrow;
    narrow = ($urandom_range(99) < 50);
    if ($urandom_range(99) < 25) begin
      b = mk_load(2'($urandom), 2'($urandom), rand_word(narrow, 19));
    end else begin
      b = mk_point(rand_word(narrow, 25), rand_word(narrow, 25), rand_word(narrow, 25),
                   narrow ? word_t'(32'h00010000) : word_t'($urandom),
                   ($urandom_range(15) == 0));
    end
    return b;
  endfunction

  // driver: prediction happens on acceptance, so the model sees beats in order
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        if (cur_beat.func == FUNC_POINT) begin
          xform_q.push_back(transform_point(cur_beat));
        end else begin
          coef_mat[{cur_beat.row, cur_beat.col}] = cur_beat.coef;
        end
        n_sent++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (beat_q.size() > 0 && !(beat_q[0].hold && xform_q.size() > 0) &&
            ((n_sent >= 600 && n_sent < 900) || $urandom_range(99) >= 12)) begin
          cur_beat = beat_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= {4'b0, cur_beat.pt, cur_beat.coef, cur_beat.col, cur_beat.row};
          s_axis_tuser_i  <= cur_beat.func;
          s_axis_tlast_i  <= cur_beat.last;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (xform_q.size() == 0) begin
          $error("output beat with no pending point");
          n_err++;
        end else begin
          xform_t exp_r;
          exp_r = xform_q.pop_front();
          for (int i = 0; i < DIM; i++) begin
            if (m_axis_tdata_o[32*i +: 32] !== exp_r.v[i]) begin
              $error("out_%s: expected %h, got %h", i == 0 ? "x" : i == 1 ? "y" :
                     i == 2 ? "z" : "w", exp_r.v[i], m_axis_tdata_o[32*i +: 32]);
              n_err++;
            end
          end
          if (m_axis_tuser_o !== exp_r.ovf) begin
            $error("overflow: expected %b, got %b", exp_r.ovf, m_axis_tuser_o);
            n_err++;
          end
          if (m_axis_tlast_o !== exp_r.last) begin
            $error("last_out: expected %b, got %b", exp_r.last, m_axis_tlast_o);
            n_err++;
          end
        end
        n_rcvd++;
      end
      if (n_rcvd == 250 && !stalled) begin
        stalled    = 1'b1;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else if (n_rcvd >= 500 && n_rcvd < 800) begin
        m_axis_tready_i <= 1'b1;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= 12);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    beat_t b;
    for (int i = 0; i < DIM*DIM; i++) begin
      coef_mat[i] = (i % (DIM + 1) == 0) ? word_t'(32'h00010000) : '0;
    end

    // identity matrix, extreme points
    beat_q.push_back(mk_point(32'h00010000, 32'h00020000, 32'hfffd0000, 32'h00010000, 1'b0));
    beat_q.push_back(mk_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1));
    beat_q.push_back(mk_point(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1'b0));
    beat_q.push_back(mk_point(32'h0, 32'h0, 32'h0, 32'h0, 1'b1));
    // extreme coefficients, saturation both ways
    beat_q.push_back(mk_load(2'd0, 2'd0, 32'h7fffffff));
    beat_q.push_back(mk_load(2'd0, 2'd1, 32'h80000000));
    beat_q.push_back(mk_load(2'd3, 2'd3, 32'hffffffff));
    beat_q.push_back(mk_load(2'd1, 2'd2, 32'h00008000));
    beat_q.push_back(mk_point(32'h7fffffff, 32'h80000000, 32'h0, 32'h0, 1'b0));
    beat_q.push_back(mk_point(32'h80000000, 32'h7fffffff, 32'h0, 32'h0, 1'b0));
    // truncation of negative sums toward minus infinity
    beat_q.push_back(mk_point(32'h0, 32'h0, 32'h00000001, 32'h00000001, 1'b0));
    beat_q.push_back(mk_point(32'h0, 32'h0, 32'hffffffff, 32'hffffffff, 1'b1));
    // full-width accumulation: four products of 2^62
    for (int c = 0; c < DIM; c++) beat_q.push_back(mk_load(2'd2, 2'(c), 32'h80000000));
    beat_q.push_back(mk_point(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1'b0));
    beat_q.push_back(mk_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0));
    beat_q.push_back(mk_point(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 1'b1));
    // back to identity on row 2
    for (int c = 0; c < DIM; c++) begin
      beat_q.push_back(mk_load(2'd2, 2'(c), (c == 2) ? 32'h00010000 : 32'h0));
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      b = rand_beat();
      b.hold = (n == 700 || n == 1200);
      beat_q.push_back(b);
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (beat_q.size() != 0 || s_axis_tvalid_i) @(posedge clk_i);
    while (xform_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (n_err == 0 && xform_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/pt4_pkg.sv
rtl/core/pt4_front.sv
rtl/core/pt4_fifo.sv
rtl/core/pt4_back.sv
rtl/core/point_transform_4x4.sv
rtl/core/pt4_checker.sv
tb/tb.sv
